// File: hw/rtl/sd_spi_command_responder_macros.svh
// ----------------------------------------------------------------------------
// SD SPI command responder assertion macros
// Clocked, reset-qualified implication checks shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef SD_SPI_COMMAND_RESPONDER_MACROS_SVH
`define SD_SPI_COMMAND_RESPONDER_MACROS_SVH

// Same-cycle implication on clk, disabled while rst_n is low.
`define SDR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sdr assertion failed");

// Next-cycle implication on clk, disabled while rst_n is low.
`define SDR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sdr assertion failed");

`endif

// File: hw/rtl/sdr_pkg.sv
// ----------------------------------------------------------------------------
// sdr_pkg
// Types, codes and the data CRC-16 step for the SD SPI command responder.
// ----------------------------------------------------------------------------
`default_nettype none

package sdr_pkg;

  localparam int unsigned BLOCK_BYTES = 512;
  localparam int unsigned BLK_SHIFT   = $clog2(BLOCK_BYTES);
  localparam int unsigned CNT_W       = 10;

  localparam logic [CNT_W-1:0] CNT_MAX       = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_BLOCK     = CNT_W'(BLOCK_BYTES);
  localparam logic [31:0]      ARG_BLOCK_LEN = 32'(BLOCK_BYTES);

  // command numbers
  localparam logic [5:0] CMD_GO_IDLE     = 6'd0;
  localparam logic [5:0] CMD_SEND_IF     = 6'd8;
  localparam logic [5:0] CMD_SEND_CSD    = 6'd9;
  localparam logic [5:0] CMD_SEND_CID    = 6'd10;
  localparam logic [5:0] CMD_STOP        = 6'd12;
  localparam logic [5:0] CMD_STATUS      = 6'd13;
  localparam logic [5:0] CMD_SET_BLKLEN  = 6'd16;
  localparam logic [5:0] CMD_READ_SINGLE = 6'd17;
  localparam logic [5:0] CMD_READ_MULTI  = 6'd18;
  localparam logic [5:0] CMD_PREERASE    = 6'd23;
  localparam logic [5:0] CMD_WRITE       = 6'd24;
  localparam logic [5:0] CMD_OP_COND     = 6'd41;
  localparam logic [5:0] CMD_APP         = 6'd55;
  localparam logic [5:0] CMD_READ_OCR    = 6'd58;
  localparam logic [5:0] CMD_CRC_ON_OFF  = 6'd59;

  // R1 status bits
  localparam logic [7:0] R1_NONE    = 8'h00;
  localparam logic [7:0] R1_IDLE    = 8'h01;
  localparam logic [7:0] R1_ILLEGAL = 8'h04;
  localparam logic [7:0] R1_CRC     = 8'h08;
  localparam logic [7:0] R1_ADDRESS = 8'h20;

  // configuration register indexes
  localparam logic [1:0] CFG_CARD_TYPE = 2'd0;
  localparam logic [1:0] CFG_EXPOSED   = 2'd1;
  localparam logic [1:0] CFG_OCR       = 2'd2;

  localparam logic [1:0] CT_SDSC = 2'd0;
  localparam logic [1:0] CT_SDHC = 2'd1;

  localparam logic [1:0] REGSEL_NONE = 2'd0;
  localparam logic [1:0] REGSEL_CSD  = 2'd1;
  localparam logic [1:0] REGSEL_CID  = 2'd2;

  typedef enum logic [2:0] {
    PH_POWERUP   = 3'd0,
    PH_IDLE      = 3'd1,
    PH_READY     = 3'd2,
    PH_TRANSFER  = 3'd3,
    PH_RECEIVING = 3'd4,
    PH_FAULT     = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    REQ_CMD  = 2'd0,
    REQ_DATA = 2'd1,
    REQ_CRC  = 2'd2,
    REQ_NEXT = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    KIND_R1   = 3'd0,
    KIND_R7   = 3'd1,
    KIND_R2   = 3'd2,
    KIND_R3   = 3'd3,
    KIND_NONE = 3'd4
  } resp_kind_t;

  typedef struct packed {
    logic [1:0]  card_type;
    logic [31:0] block_count;
    logic [31:0] ocr_value;
  } sdr_cfg_t;

  typedef struct packed {
    req_type_t   req_type;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_argument;
    logic [7:0]  data_byte;
    logic [15:0] data_crc;
  } sdr_req_t;

  typedef struct packed {
    phase_t           phase;
    logic             crc_check_on;
    logic             app_prefix_seen;
    logic             multi_read_on;
    logic [31:0]      next_read_block;
    logic [31:0]      write_target_block;
    logic [31:0]      preerase_count;
    logic [15:0]      data_crc_acc;
    logic [CNT_W-1:0] data_byte_count;
  } sdr_state_t;

  typedef struct packed {
    resp_kind_t  resp_kind;
    logic [7:0]  r1_byte;
    logic [31:0] resp_payload;
    logic [1:0]  register_select;
    logic        read_start;
    logic        write_commit;
    logic [31:0] block_address;
    logic        multi_ok;
  } sdr_result_t;

  // CRC-16/XMODEM (poly 0x1021), one byte MSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sdr_step.sv
// ----------------------------------------------------------------------------
// sdr_step
// Next card state and response for one request, pure combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module sdr_step
  import sdr_pkg::*;
(
  input  sdr_cfg_t    cfg,
  input  sdr_state_t  st,
  input  sdr_req_t    req,
  output sdr_state_t  st_nxt,
  output sdr_result_t res
);

  logic [7:0]  idle_bit;
  logic        rdy_xfer;
  logic        sound;
  logic [31:0] blk;
  logic        addr_bad;
  logic        crc_good;

  assign idle_bit = (st.phase == PH_IDLE) ? R1_IDLE : R1_NONE;
  assign rdy_xfer = (st.phase == PH_READY) || (st.phase == PH_TRANSFER);
  assign sound    = (st.phase != PH_POWERUP) && (st.phase != PH_FAULT);

  // SDSC takes byte addresses that must sit on a block boundary
  always_comb begin
    if (cfg.card_type == CT_SDSC) begin
      blk      = {{BLK_SHIFT{1'b0}}, req.cmd_argument[31:BLK_SHIFT]};
      addr_bad = (req.cmd_argument[BLK_SHIFT-1:0] != '0);
    end else begin
      blk      = req.cmd_argument;
      addr_bad = 1'b0;
    end
  end

  assign crc_good = (st.data_byte_count == CNT_BLOCK) && (st.data_crc_acc == req.data_crc);

  always_comb begin
    st_nxt = st;
    res    = '0;
    res.resp_kind = KIND_R1;

    case (req.req_type)
      REQ_CMD: begin
        if (!(req.cmd_index inside {CMD_APP, CMD_OP_COND, CMD_PREERASE})) begin
          st_nxt.app_prefix_seen = 1'b0;
        end
        if (req.cmd_index == CMD_GO_IDLE) begin
          st_nxt.phase         = PH_IDLE;
          st_nxt.crc_check_on  = 1'b0;
          st_nxt.multi_read_on = 1'b0;
          res.r1_byte          = R1_IDLE;
        end else if (req.cmd_index == CMD_SEND_IF && st.phase == PH_IDLE) begin
          res.resp_kind    = KIND_R7;
          res.r1_byte      = idle_bit;
          res.resp_payload = req.cmd_argument;
        end else if (req.cmd_index == CMD_STATUS && sound) begin
          res.resp_kind = KIND_R2;
          res.r1_byte   = idle_bit;
        end else if (req.cmd_index == CMD_STOP && st.phase == PH_TRANSFER) begin
          st_nxt.multi_read_on = 1'b0;
        end else if (req.cmd_index == CMD_CRC_ON_OFF && req.cmd_argument[31:1] == '0
                     && sound) begin
          st_nxt.crc_check_on = req.cmd_argument[0];
          res.r1_byte         = idle_bit;
        end else if (req.cmd_index == CMD_APP) begin
          st_nxt.app_prefix_seen = 1'b1;
          res.r1_byte            = idle_bit;
        end else if (req.cmd_index == CMD_OP_COND && st.app_prefix_seen
                     && st.phase == PH_IDLE) begin
          st_nxt.phase           = PH_READY;
          st_nxt.app_prefix_seen = 1'b0;
        end else if (req.cmd_index == CMD_PREERASE && st.app_prefix_seen && rdy_xfer) begin
          st_nxt.preerase_count  = req.cmd_argument;
          st_nxt.app_prefix_seen = 1'b0;
          res.r1_byte            = idle_bit;
        end else if (req.cmd_index == CMD_READ_OCR && rdy_xfer) begin
          res.resp_kind    = KIND_R3;
          res.r1_byte      = idle_bit;
          res.resp_payload = cfg.ocr_value;
        end else if ((req.cmd_index inside {CMD_SEND_CSD, CMD_SEND_CID}) && rdy_xfer) begin
          st_nxt.phase        = PH_TRANSFER;
          res.register_select = (req.cmd_index == CMD_SEND_CSD) ? REGSEL_CSD : REGSEL_CID;
        end else if (req.cmd_index == CMD_SET_BLKLEN && req.cmd_argument == ARG_BLOCK_LEN
                     && (cfg.card_type inside {CT_SDSC, CT_SDHC})) begin
          res.r1_byte = idle_bit;
        end else if ((req.cmd_index inside {CMD_READ_SINGLE, CMD_READ_MULTI, CMD_WRITE})
                     && rdy_xfer) begin
          if (addr_bad || blk >= cfg.block_count) begin
            res.r1_byte = R1_ADDRESS;
          end else if (req.cmd_index == CMD_WRITE) begin
            st_nxt.write_target_block = blk;
            st_nxt.phase              = PH_RECEIVING;
            st_nxt.data_crc_acc       = '0;
            st_nxt.data_byte_count    = '0;
          end else begin
            st_nxt.phase      = PH_TRANSFER;
            res.read_start    = 1'b1;
            res.block_address = blk;
            if (req.cmd_index == CMD_READ_MULTI) begin
              st_nxt.multi_read_on   = 1'b1;
              st_nxt.next_read_block = blk + 32'd1;
            end
          end
        end else begin
          res.r1_byte = R1_ILLEGAL | idle_bit;
        end
      end

      REQ_DATA: begin
        res.resp_kind = KIND_NONE;
        if (st.phase == PH_RECEIVING) begin
          st_nxt.data_crc_acc = crc16_byte(st.data_crc_acc, req.data_byte);
          if (st.data_byte_count != CNT_MAX) begin
            st_nxt.data_byte_count = st.data_byte_count + CNT_W'(1);
          end
        end
      end

      REQ_CRC: begin
        if (st.phase != PH_RECEIVING) begin
          res.r1_byte = R1_CRC;
        end else begin
          st_nxt.data_crc_acc    = '0;
          st_nxt.data_byte_count = '0;
          if (!crc_good) begin
            res.r1_byte = R1_CRC;
          end else begin
            st_nxt.phase      = PH_TRANSFER;
            res.write_commit  = 1'b1;
            res.block_address = st.write_target_block;
          end
        end
      end

      REQ_NEXT: begin
        res.resp_kind = KIND_NONE;
        if (st.multi_read_on && st.next_read_block < cfg.block_count) begin
          res.multi_ok           = 1'b1;
          res.read_start         = 1'b1;
          res.block_address      = st.next_read_block;
          st_nxt.next_read_block = st.next_read_block + 32'd1;
        end
      end

      default: begin
        res.resp_kind = KIND_NONE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/sd_spi_command_responder.sv
// ----------------------------------------------------------------------------
// sd_spi_command_responder
// Card-side SD SPI-mode command handler: one request in, one response out.
// ----------------------------------------------------------------------------
// Each request (command, write-data byte, closing data CRC or next multi-read
// block) yields exactly one result word. Throughput is one request per clock
// unless the result stalls. An accepted request is held in the input register,
// then the single-pass decode/CRC step loads the result register and raises
// out_tvalid. The card state is updated in the same edge that loads the result
// register, so the following request sees it with no bubble. A stalled result
// stalls the input side only once the input register is also full.
// Configuration (card type, exposed block count, OCR) is written through
// cfg_*; the user must write it only while idle, the block does not enforce
// it. Block data and the CSD/CID contents live outside; this block only issues
// read/write strobes with a block address and the register selects.
`default_nettype none

module sd_spi_command_responder
  import sdr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata,

  input  wire logic        in_tvalid,
  output      logic        in_tready,
  // [5:0] cmd_index, [37:6] cmd_argument, [45:38] data_byte,
  // [61:46] data_crc, [63:62] zero
  input  wire logic [63:0] in_tdata,
  // [1:0] req_type
  input  wire logic [1:0]  in_tuser,

  output      logic        out_tvalid,
  input  wire logic        out_tready,
  // [7:0] r1_byte, [39:8] resp_payload, [41:40] register_select,
  // [42] read_start, [43] write_commit, [75:44] block_address,
  // [76] multi_ok, [79:77] zero
  output      logic [79:0] out_tdata,
  // [2:0] resp_kind
  output      logic [2:0]  out_tuser
);

  sdr_cfg_t    cfg_r;
  sdr_req_t    req_r;
  logic        req_valid_r;
  sdr_state_t  st_r;
  sdr_state_t  st_nxt;
  sdr_result_t res_r;
  sdr_result_t res_nxt;
  logic        out_valid_r;
  logic        step_go;

  // request register moves into the result register when the latter is free;
  // no word is taken while in reset
  assign step_go   = req_valid_r && (!out_valid_r || out_tready);
  assign in_tready = rst_n && (!req_valid_r || !out_valid_r || out_tready);

  sdr_step u_step (
    .cfg    (cfg_r),
    .st     (st_r),
    .req    (req_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // control and card state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r              <= 1'b0;
      out_valid_r              <= 1'b0;
      cfg_r.card_type          <= CT_SDHC;
      cfg_r.block_count        <= '0;
      cfg_r.ocr_value          <= '0;
      st_r.phase               <= PH_POWERUP;
      st_r.crc_check_on        <= 1'b0;
      st_r.app_prefix_seen     <= 1'b0;
      st_r.multi_read_on       <= 1'b0;
      st_r.next_read_block     <= '0;
      st_r.write_target_block  <= '0;
      st_r.preerase_count      <= '0;
      st_r.data_crc_acc        <= '0;
      st_r.data_byte_count     <= '0;
    end else begin
      if (in_tready) begin
        req_valid_r <= in_tvalid;
      end
      if (step_go) begin
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_CARD_TYPE: cfg_r.card_type   <= cfg_wdata[1:0];
          CFG_EXPOSED:   cfg_r.block_count <= cfg_wdata;
          CFG_OCR:       cfg_r.ocr_value   <= cfg_wdata;
          default:       ;
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      req_r.req_type     <= req_type_t'(in_tuser);
      req_r.cmd_index    <= in_tdata[5:0];
      req_r.cmd_argument <= in_tdata[37:6];
      req_r.data_byte    <= in_tdata[45:38];
      req_r.data_crc     <= in_tdata[61:46];
    end
    if (step_go) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.resp_kind;
  assign out_tdata  = {3'b000,
                       res_r.multi_ok,
                       res_r.block_address,
                       res_r.write_commit,
                       res_r.read_start,
                       res_r.register_select,
                       res_r.resp_payload,
                       res_r.r1_byte};

  `include "sd_spi_command_responder_macros.svh"

  // a write commit leaves the card in transfer until the next result loads
  `SDR_ASSERT_IMPL(a_commit_xfer, out_valid_r && res_r.write_commit, st_r.phase == PH_TRANSFER)
  // read and write strobes are exclusive
  `SDR_ASSERT_IMPL(a_rd_wr_excl, out_valid_r, !(res_r.read_start && res_r.write_commit))
  // a no-response result carries no R1 bits
  `SDR_ASSERT_IMPL(a_none_r1, out_valid_r && res_r.resp_kind == KIND_NONE,
                   res_r.r1_byte == R1_NONE)
  // a stalled result holds the step and the card state
  `SDR_ASSERT_NEXT(a_stall_hold, out_valid_r && !out_tready, st_r == $past(st_r))

endmodule

`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// SD SPI command responder testbench
// Drives request words (commands, write-data bytes, closing data CRCs and
// next-block requests) into the responder, predicts every response word with
// a behavioral card model held here, and compares each response field by
// field. Covers power-up, card init, every command, a full committed write
// block, short and broken write blocks, and randomized traffic over several
// card configurations, with random idling on both stream sides.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sdr_pkg::*;

  // card types without a name in the package
  localparam logic [1:0] CT_SDXC = 2'd2;
  localparam logic [1:0] CT_RSVD = 2'd3;

  // a command number the card never knows
  localparam logic [5:0] CMD_UNDEFINED = 6'd63;

  localparam int GAP_MAX      = 18;
  localparam int STALL_LIMIT  = 1000;
  localparam int RANDOM_WORDS = 1080;
  localparam int RANDOM_PHASES = 6;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;
  logic        in_tvalid;
  wire         in_tready;
  logic [63:0] in_tdata;
  logic [1:0]  in_tuser;
  wire         out_tvalid;
  logic        out_tready;
  wire  [79:0] out_tdata;
  wire  [2:0]  out_tuser;

  // card model: configuration
  logic [1:0]  m_card_type;
  logic [31:0] m_exposed;
  logic [31:0] m_ocr;

  // card model: state
  phase_t      m_phase;
  logic        m_crc_on;
  logic        m_app_seen;
  logic        m_multi_on;
  logic [31:0] m_next_blk;
  logic [31:0] m_wr_blk;
  logic [31:0] m_preerase;
  logic [15:0] m_crc_acc;
  logic [9:0]  m_byte_cnt;

  sdr_result_t pending_responses[$];

  int fail_count = 0;
  int unsigned words_sent = 0;
  int src_gap_max = GAP_MAX;
  int sink_gap_max = GAP_MAX;
  int sink_wait;
  int idle_cycles;

  sd_spi_command_responder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Card model
  // --------------------------------------------------------------------------

  // CRC-16/XMODEM, bit-serial LFSR form, MSB first
  function automatic logic [15:0] crc16_step(logic [15:0] acc, logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
    end
    return c;
  endfunction

  function automatic void card_model_reset();
    m_card_type = CT_SDHC;
    m_exposed   = '0;
    m_ocr       = '0;
    m_phase     = PH_POWERUP;
    m_crc_on    = 1'b0;
    m_app_seen  = 1'b0;
    m_multi_on  = 1'b0;
    m_next_blk  = '0;
    m_wr_blk    = '0;
    m_preerase  = '0;
    m_crc_acc   = '0;
    m_byte_cnt  = '0;
  endfunction

  // Advances the card model by one request and returns the response word.
  function automatic sdr_result_t card_respond(req_type_t rt, logic [5:0] idx,
                                               logic [31:0] arg, logic [7:0] db,
                                               logic [15:0] dcrc);
    sdr_result_t r;
    logic [7:0]  idle;
    logic [31:0] blk;
    logic        rdy_xfer;
    logic        sound;
    logic        good;
    r = '0;
    r.resp_kind = KIND_R1;
    idle = (m_phase == PH_IDLE) ? R1_IDLE : R1_NONE;
    rdy_xfer = (m_phase == PH_READY) || (m_phase == PH_TRANSFER);
    sound = (m_phase != PH_POWERUP) && (m_phase != PH_FAULT);
    case (rt)
      REQ_DATA: begin
        r.resp_kind = KIND_NONE;
        if (m_phase == PH_RECEIVING) begin
          m_crc_acc = crc16_step(m_crc_acc, db);
          if (m_byte_cnt != 10'h3FF) m_byte_cnt++;
        end
      end
      REQ_CRC: begin
        if (m_phase != PH_RECEIVING) begin
          r.r1_byte = R1_CRC;
        end else begin
          good = (m_byte_cnt == 10'd512) && (m_crc_acc == dcrc);
          m_crc_acc = '0;
          m_byte_cnt = '0;
          if (!good) begin
            r.r1_byte = R1_CRC;
          end else begin
            m_phase = PH_TRANSFER;
            r.write_commit = 1'b1;
            r.block_address = m_wr_blk;
          end
        end
      end
      REQ_NEXT: begin
        r.resp_kind = KIND_NONE;
        if (m_multi_on && m_next_blk < m_exposed) begin
          r.multi_ok = 1'b1;
          r.read_start = 1'b1;
          r.block_address = m_next_blk;
          m_next_blk++;
        end
      end
      default: begin
        // only the app prefix and the two app commands leave the prefix alone
        if (idx != CMD_APP && idx != CMD_OP_COND && idx != CMD_PREERASE)
          m_app_seen = 1'b0;
        if (idx == CMD_GO_IDLE) begin
          m_phase = PH_IDLE;
          m_crc_on = 1'b0;
          m_multi_on = 1'b0;
          r.r1_byte = R1_IDLE;
        end else if (idx == CMD_SEND_IF && m_phase == PH_IDLE) begin
          r.resp_kind = KIND_R7;
          r.r1_byte = idle;
          r.resp_payload = arg;
        end else if (idx == CMD_STATUS && sound) begin
          r.resp_kind = KIND_R2;
          r.r1_byte = idle;
        end else if (idx == CMD_STOP && m_phase == PH_TRANSFER) begin
          m_multi_on = 1'b0;
        end else if (idx == CMD_CRC_ON_OFF && arg <= 32'd1 && sound) begin
          m_crc_on = arg[0];
          r.r1_byte = idle;
        end else if (idx == CMD_APP) begin
          m_app_seen = 1'b1;
          r.r1_byte = idle;
        end else if (idx == CMD_OP_COND && m_app_seen && m_phase == PH_IDLE) begin
          m_phase = PH_READY;
          m_app_seen = 1'b0;
        end else if (idx == CMD_PREERASE && m_app_seen && rdy_xfer) begin
          m_preerase = arg;
          m_app_seen = 1'b0;
          r.r1_byte = idle;
        end else if (idx == CMD_READ_OCR && rdy_xfer) begin
          r.resp_kind = KIND_R3;
          r.r1_byte = idle;
          r.resp_payload = m_ocr;
        end else if ((idx == CMD_SEND_CSD || idx == CMD_SEND_CID) && rdy_xfer) begin
          m_phase = PH_TRANSFER;
          r.register_select = (idx == CMD_SEND_CSD) ? REGSEL_CSD : REGSEL_CID;
        end else if (idx == CMD_SET_BLKLEN && arg == ARG_BLOCK_LEN &&
                     (m_card_type == CT_SDSC || m_card_type == CT_SDHC)) begin
          r.r1_byte = idle;
        end else if ((idx == CMD_READ_SINGLE || idx == CMD_READ_MULTI ||
                      idx == CMD_WRITE) && rdy_xfer) begin
          // standard capacity takes byte addresses on block boundaries
          blk = (m_card_type == CT_SDSC) ? (arg >> 9) : arg;
          if (m_card_type == CT_SDSC && arg[8:0] != 9'd0) begin
            r.r1_byte = R1_ADDRESS;
          end else if (blk >= m_exposed) begin
            r.r1_byte = R1_ADDRESS;
          end else if (idx == CMD_WRITE) begin
            m_wr_blk = blk;
            m_phase = PH_RECEIVING;
            m_crc_acc = '0;
            m_byte_cnt = '0;
          end else begin
            m_phase = PH_TRANSFER;
            r.read_start = 1'b1;
            r.block_address = blk;
            if (idx == CMD_READ_MULTI) begin
              m_multi_on = 1'b1;
              m_next_blk = blk + 32'd1;
            end
          end
        end else begin
          r.r1_byte = R1_ILLEGAL | idle;
        end
      end
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // One request word. Valid stays high on return so back-to-back words need
  // no low cycle; whoever pauses the stream lowers it.
  task automatic send_word(req_type_t rt, logic [5:0] idx, logic [31:0] arg,
                           logic [7:0] db, logic [15:0] dcrc);
    int gap;
    gap = (src_gap_max > 0) ? $urandom_range(0, src_gap_max) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= rt;
    in_tdata  <= {2'b00, dcrc, db, arg, idx};
    do @(posedge clk); while (!in_tready);
    pending_responses.push_back(card_respond(rt, idx, arg, db, dcrc));
    words_sent++;
  endtask

  // unused fields carry random bits on every word
  task automatic send_cmd(logic [5:0] idx, logic [31:0] arg);
    send_word(REQ_CMD, idx, arg, 8'($urandom), 16'($urandom));
  endtask

  task automatic send_byte(logic [7:0] b);
    send_word(REQ_DATA, 6'($urandom), $urandom, b, 16'($urandom));
  endtask

  task automatic send_crc(logic [15:0] c);
    send_word(REQ_CRC, 6'($urandom), $urandom, 8'($urandom), c);
  endtask

  task automatic send_next();
    send_word(REQ_NEXT, 6'($urandom), $urandom, 8'($urandom), 16'($urandom));
  endtask

  // hold the stream until every response is back, then let the pipe settle
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // writes all three registers; only called with the card drained
  task automatic configure_card(logic [1:0] ct, logic [31:0] blocks, logic [31:0] ocr);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CARD_TYPE;
    cfg_wdata <= {30'd0, ct};
    @(posedge clk);
    cfg_index <= CFG_EXPOSED;
    cfg_wdata <= blocks;
    @(posedge clk);
    cfg_index <= CFG_OCR;
    cfg_wdata <= ocr;
    @(posedge clk);
    cfg_we <= 1'b0;
    m_card_type = ct;
    m_exposed = blocks;
    m_ocr = ocr;
    @(posedge clk);
  endtask

  // quiet stretches on either side now and then
  function automatic void pick_pacing();
    src_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
    sink_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
  endfunction

  function automatic logic [31:0] rand_arg();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'($urandom_range(0, 2));
      3: return ARG_BLOCK_LEN;
      default: return $urandom;
    endcase
  endfunction

  // Mostly a block inside the card (often the last one), in the addressing
  // the current card type uses; sometimes a raw random argument.
  function automatic logic [31:0] addr_arg();
    logic [31:0] top;
    logic [31:0] blk;
    if (m_exposed == 0 || $urandom_range(0, 9) == 0) return $urandom;
    top = m_exposed;
    if (m_card_type == CT_SDSC && top > 32'h0080_0000) top = 32'h0080_0000;
    blk = ($urandom_range(0, 3) == 0) ? top - 32'd1 : $urandom_range(0, top - 32'd1);
    return (m_card_type == CT_SDSC) ? {blk[22:0], 9'd0} : blk;
  endfunction

  // GO_IDLE, interface check, optional CRC switch, app prefix, op-cond
  task automatic bring_up();
    send_cmd(CMD_GO_IDLE, rand_arg());
    send_cmd(CMD_SEND_IF, rand_arg());
    if ($urandom_range(0, 1) == 1) send_cmd(CMD_CRC_ON_OFF, 32'($urandom_range(0, 1)));
    send_cmd(CMD_APP, rand_arg());
    send_cmd(CMD_OP_COND, rand_arg());
  endtask

  // count random data bytes followed by their CRC, or a CRC with one bit off
  task automatic stream_block(int unsigned count, bit crc_good);
    logic [15:0] acc;
    logic [7:0]  b;
    acc = '0;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 64 == 0) pick_pacing();
      b = 8'($urandom);
      acc = crc16_step(acc, b);
      send_byte(b);
    end
    send_crc(crc_good ? acc : acc ^ (16'd1 << $urandom_range(0, 15)));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // power-up behavior on reset config, then first configuration and card init
  task automatic test_power_up();
    send_cmd(CMD_SEND_IF, 32'h0000_01AA);   // not idle yet: illegal, no idle bit
    send_cmd(CMD_SET_BLKLEN, ARG_BLOCK_LEN); // reset card type takes 512
    send_byte(8'hFF);                        // ignored outside a write
    send_crc(16'hFFFF);                      // stray CRC flags a CRC error
    send_next();                             // no multi read running
    drain_results();
    configure_card(CT_SDHC, 32'd64, 32'hC0FF_8000);
    send_cmd(CMD_GO_IDLE, 32'hFFFF_FFFF);
    send_cmd(CMD_SEND_IF, 32'hFFFF_FFFF);    // R7 echoes the argument
    send_cmd(CMD_OP_COND, 32'd0);            // no app prefix: illegal
    send_cmd(CMD_APP, 32'd0);
    send_cmd(CMD_PREERASE, 32'hFFFF_FFFF);   // wrong phase: illegal, prefix kept
    send_cmd(CMD_OP_COND, 32'hFFFF_FFFF);    // prefix still there: ready
  endtask

  // commands in ready/transfer, multi read running off the end
  task automatic test_command_set();
    send_cmd(CMD_CRC_ON_OFF, 32'd2);         // only 0 and 1 are legal
    send_cmd(CMD_READ_OCR, 32'd0);
    send_cmd(CMD_SEND_CSD, 32'd0);
    send_cmd(CMD_SEND_CID, 32'd0);
    send_cmd(CMD_STATUS, 32'd0);
    send_cmd(CMD_READ_SINGLE, 32'd64);       // one past the last block
    send_cmd(CMD_READ_MULTI, 32'd62);
    repeat (3) send_next();                  // block 63, then out of blocks
    send_cmd(CMD_STOP, 32'd0);
    send_next();                             // stopped: nothing more
    send_cmd(CMD_UNDEFINED, 32'hFFFF_FFFF);
  endtask

  // A proper 512-byte block with its CRC commits to the target block and
  // brings the card back to transfer.
  task automatic test_block_write();
    send_cmd(CMD_WRITE, 32'd7);
    stream_block(BLOCK_BYTES, 1'b1);
    pick_pacing();
  endtask

  // Random traffic over several card configurations. Each phase drains,
  // reconfigures and re-inits the card, then mixes well-formed sequences
  // (init, reads, multi reads, writes) with stray and random words.
  task automatic test_random_traffic();
    int unsigned phase_end;
    int          pick;
    logic [1:0]  ct;
    logic [31:0] blocks;
    logic [31:0] ocr;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin ct = CT_SDSC; blocks = 32'd16;        ocr = 32'd0;        end
        1: begin ct = CT_SDHC; blocks = 32'd0;         ocr = 32'hFFFF_FFFF; end
        2: begin ct = CT_SDXC; blocks = 32'hFFFF_FFFF; ocr = $urandom;     end
        3: begin ct = CT_RSVD; blocks = 32'($urandom_range(1, 4096)); ocr = $urandom; end
        4: begin ct = CT_SDSC; blocks = 32'hFFFF_FFFF; ocr = $urandom;     end
        default: begin ct = CT_SDHC; blocks = $urandom; ocr = $urandom;   end
      endcase
      drain_results();
      configure_card(ct, blocks, ocr);
      bring_up();
      phase_end = words_sent + RANDOM_WORDS / RANDOM_PHASES;
      while (words_sent < phase_end) begin
        if ($urandom_range(0, 7) == 0) pick_pacing();
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          bring_up();
        end else if (pick < 30) begin
          send_cmd(CMD_READ_SINGLE, addr_arg());
        end else if (pick < 45) begin
          send_cmd(CMD_READ_MULTI, addr_arg());
          repeat ($urandom_range(1, 6)) send_next();
          if ($urandom_range(0, 9) < 7) send_cmd(CMD_STOP, rand_arg());
        end else if (pick < 60) begin
          // short block: always a count error; usually recover via re-init
          send_cmd(CMD_WRITE, addr_arg());
          stream_block($urandom_range(0, 24), 1'($urandom_range(0, 1)));
          if ($urandom_range(0, 2) != 0) bring_up();
        end else if (pick < 63) begin
          // a write left open: the card keeps receiving until re-init
          send_cmd(CMD_WRITE, addr_arg());
        end else if (pick < 80) begin
          case ($urandom_range(0, 8))
            0: send_cmd(CMD_SEND_CSD, rand_arg());
            1: send_cmd(CMD_SEND_CID, rand_arg());
            2: send_cmd(CMD_STATUS, rand_arg());
            3: send_cmd(CMD_READ_OCR, rand_arg());
            4: send_cmd(CMD_CRC_ON_OFF, rand_arg());
            5: send_cmd(CMD_SET_BLKLEN, rand_arg());
            6: begin
              send_cmd(CMD_APP, rand_arg());
              send_cmd(CMD_PREERASE, rand_arg());
            end
            7: send_cmd(CMD_SEND_IF, rand_arg());
            default: send_cmd(CMD_STOP, rand_arg());
          endcase
        end else if (pick < 90) begin
          case ($urandom_range(0, 2))
            0: send_byte(8'($urandom));
            1: send_crc(16'($urandom));
            default: send_next();
          endcase
        end else begin
          send_word(req_type_t'(2'($urandom)), 6'($urandom), rand_arg(),
                    8'($urandom), 16'($urandom));
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Response side: random back-pressure, checking, watchdog
  // --------------------------------------------------------------------------

  // after each accepted response, hold tready low for a random stall
  always @(posedge clk) begin : sink_pacing
    int stall;
    if (!rst_n) begin
      out_tready <= 1'b0;
      sink_wait  <= 0;
    end else if (out_tvalid && out_tready) begin
      stall = (sink_gap_max > 0) ? $urandom_range(0, sink_gap_max) : 0;
      out_tready <= (stall == 0);
      sink_wait  <= stall;
    end else if (sink_wait > 0) begin
      sink_wait  <= sink_wait - 1;
      out_tready <= (sink_wait == 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // each accepted response word against the oldest prediction
  always @(posedge clk) begin : response_check
    sdr_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_responses.size() == 0) begin
        $display("%0t: response word with none expected: expected none, actual %h/%h",
                 $time, out_tuser, out_tdata);
        fail_count++;
      end else begin
        want = pending_responses.pop_front();
        check_field("resp_kind",       32'(want.resp_kind),       32'(out_tuser));
        check_field("r1_byte",         32'(want.r1_byte),         32'(out_tdata[7:0]));
        check_field("resp_payload",    want.resp_payload,         out_tdata[39:8]);
        check_field("register_select", 32'(want.register_select), 32'(out_tdata[41:40]));
        check_field("read_start",      32'(want.read_start),      32'(out_tdata[42]));
        check_field("write_commit",    32'(want.write_commit),    32'(out_tdata[43]));
        check_field("block_address",   want.block_address,        out_tdata[75:44]);
        check_field("multi_ok",        32'(want.multi_ok),        32'(out_tdata[76]));
      end
    end
  end

  // ends the run if neither side moves a word for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= CFG_CARD_TYPE;
    cfg_wdata  <= '0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= REQ_CMD;
    card_model_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_power_up();
    test_command_set();
    test_block_write();
    test_random_traffic();

    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+hw/rtl
hw/rtl/sdr_pkg.sv
hw/rtl/sdr_step.sv
hw/rtl/sd_spi_command_responder.sv
tb/testbench.sv
